// ===== rtl/core/b32d_pkg.sv =====
package b32d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SymW   = 5;
  localparam int unsigned CountW = 8;
  localparam int unsigned BitsW  = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_LEFTOVER = 2'd3
  } status_t;

  typedef struct packed {
    logic            hit;
    logic [SymW-1:0] value;
  } sym_t;

  // Digits, then b..z without e, i, o; either case.
  function automatic sym_t symbol_decode(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    logic [CharW-1:0] v;
    sym_t             s;
    s.hit   = 1'b0;
    s.value = '0;
    lc      = c;
    v       = '0;
    if (c[CharW-1]) begin
      s.hit = 1'b0;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v       = c - 8'h30;
      s.hit   = 1'b1;
      s.value = v[SymW-1:0];
    end else begin
      if (c >= 8'h41 && c <= 8'h5a) begin
        lc = c + 8'h20;
      end
      if (lc < 8'h62 || lc > 8'h7a || lc == 8'h65 || lc == 8'h69 || lc == 8'h6f) begin
        s.hit = 1'b0;
      end else begin
        v = lc - 8'h62 + 8'd10;
        if (lc > 8'h65) begin
          v = v - 8'd1;
        end
        if (lc > 8'h69) begin
          v = v - 8'd1;
        end
        if (lc > 8'h6f) begin
          v = v - 8'd1;
        end
        s.hit   = 1'b1;
        s.value = v[SymW-1:0];
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/core/base32_lsb_first_decoder.sv =====
// Base32 decoder, LSB-first packing, one character per word.
// Input stream: s_axis_tdata carries one character, s_axis_tlast marks the
// final character of a string. Each character gives exactly one output word.
// Output stream: m_axis_tdata holds the decoded byte (low) and the running
// byte count (high); m_axis_tuser holds the byte-valid flag and the status
// (0 ok, 1 bad character, 2 overflow, 3 leftover bits); m_axis_tlast
// marks the word for the last character, which carries the final status.
// The output word is valid in the cycle after input acceptance.
// Throughput: one character per cycle, set by the single output register;
// the decode, pack and status update all sit in one combinational step.
// Stall: while the output word is held, s_axis_tready drops; it stays high
// when the held word is taken in the same cycle.
// The first error in a string is latched; later characters emit no bytes.
// cfg_data sets the most bytes per string (reset 255); write only when idle.
// Reset (rst, synchronous) clears the string state and output valid.
module base32_lsb_first_decoder
  import b32d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,       // max_out_len
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // data_byte[7:0], out_count[15:8]
  output logic [2:0]  m_axis_tuser,   // byte_valid[0], status[2:1]
  output logic        m_axis_tlast    // string_done
);

  localparam int unsigned WideW = CountW + SymW;

  logic [CountW-1:0] max_out_len;
  logic [CountW-1:0] bit_acc;
  logic [BitsW-1:0]  bit_count;
  logic [CountW-1:0] byte_count;
  status_t           error_code;

  logic [CountW-1:0] bit_acc_next;
  logic [BitsW-1:0]  bit_count_next;
  logic [CountW-1:0] byte_count_next;
  status_t           error_code_next;

  logic [CountW-1:0] out_byte_next;
  logic              out_valid_next;
  status_t           out_status_next;
  logic [CountW-1:0] out_count_next;

  logic [CountW-1:0] out_byte;
  logic              out_byte_valid;
  status_t           out_status;
  logic [CountW-1:0] out_count;
  logic              out_last;
  logic              out_vld;

  sym_t              sym;
  logic [WideW-1:0]  wide;
  logic [BitsW:0]    nbits;
  logic              s_accept;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_vld || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign sym   = symbol_decode(s_axis_tdata);
  assign wide  = {{SymW{1'b0}}, bit_acc} | ({{CountW{1'b0}}, sym.value} << bit_count);
  assign nbits = {1'b0, bit_count} + 4'd5;

  always_comb begin
    bit_acc_next    = bit_acc;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    error_code_next = error_code;
    out_byte_next   = '0;
    out_valid_next  = 1'b0;
    if (error_code == ST_OK) begin
      if (!sym.hit) begin
        error_code_next = ST_BAD_CHAR;
      end else if (nbits >= 4'd8) begin
        if (byte_count >= max_out_len) begin
          error_code_next = ST_OVERFLOW;
        end else begin
          out_byte_next   = wide[CountW-1:0];
          out_valid_next  = 1'b1;
          byte_count_next = byte_count + 8'd1;
          bit_acc_next    = {{(CountW-SymW){1'b0}}, wide[WideW-1:CountW]};
          bit_count_next  = nbits[BitsW-1:0];
        end
      end else begin
        bit_acc_next   = wide[CountW-1:0];
        bit_count_next = nbits[BitsW-1:0];
      end
    end
    if (s_axis_tlast && error_code_next == ST_OK &&
        (bit_count_next >= 3'd5 || bit_acc_next != '0)) begin
      error_code_next = ST_LEFTOVER;
    end
    out_status_next = error_code_next;
    out_count_next  = byte_count_next;
    if (s_axis_tlast) begin
      bit_acc_next    = '0;
      bit_count_next  = '0;
      byte_count_next = '0;
      error_code_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= 8'd255;
      bit_acc     <= '0;
      bit_count   <= '0;
      byte_count  <= '0;
      error_code  <= ST_OK;
      out_vld     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_out_len <= cfg_data;
      end
      if (s_accept) begin
        bit_acc    <= bit_acc_next;
        bit_count  <= bit_count_next;
        byte_count <= byte_count_next;
        error_code <= error_code_next;
        out_vld    <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_byte       <= out_byte_next;
      out_byte_valid <= out_valid_next;
      out_status     <= out_status_next;
      out_count      <= out_count_next;
      out_last       <= s_axis_tlast;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {out_count, out_byte};
  assign m_axis_tuser  = {out_status, out_byte_valid};
  assign m_axis_tlast  = out_last;

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_axis_tlast |=>
      bit_count == '0 && byte_count == '0 && bit_acc == '0 && error_code == ST_OK)
    else $error("string state not cleared after last character");

  a_byte_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_byte_valid |-> out_status == ST_OK || out_status == ST_LEFTOVER)
    else $error("byte emitted alongside an error status");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> $stable(byte_count) && $stable(bit_count) && $stable(error_code))
    else $error("string state changed without an accepted character");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    s_accept && !s_axis_tlast && error_code != ST_OK |=>
      error_code == $past(error_code))
    else $error("latched error changed within a string");
`endif

endmodule
